### rtl/rbp_pkg.sv
// ----------------------------------------------------------------------------
// rbp_pkg
// Shared types and constants of the best-path route table.
// ----------------------------------------------------------------------------
`default_nettype none

package rbp_pkg;

  localparam int PREFIX_ENTRIES = 1024;
  localparam int MAX_PATH_LEN   = 255;
  localparam int ADDR_W         = $clog2(PREFIX_ENTRIES);

  // field widths
  localparam int IDX_W  = 10;
  localparam int RANK_W = 2;
  localparam int LEN_W  = 8;
  localparam int ASN_W  = 32;

  localparam logic [LEN_W-1:0] LEN_CAP =
    (MAX_PATH_LEN < 255) ? LEN_W'(MAX_PATH_LEN) : LEN_W'(255);

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_PREPEND_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OWN_ASN      = CFG_IDX_W'(1);

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 80;

  typedef struct packed {
    logic              prepend_mode;
    logic [ASN_W-1:0]  own_asn;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]  prefix_index;
    logic [RANK_W-1:0] relationship;
    logic [LEN_W-1:0]  path_length;
    logic [ASN_W-1:0]  path_head_asn;
    logic [ASN_W-1:0]  next_hop;
    logic              rov_flag;
  } req_t;

  typedef struct packed {
    logic              valid;
    logic [RANK_W-1:0] relationship;
    logic [LEN_W-1:0]  length;
    logic [ASN_W-1:0]  head_asn;
    logic [ASN_W-1:0]  next_hop;
    logic              rov;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

### rtl/route_best_path_table.sv
// ----------------------------------------------------------------------------
// route_best_path_table
// Per-prefix best route table: one announcement in, one result out.
// ----------------------------------------------------------------------------
// Takes one announcement per clock unless out_tready stalls or the clearing
// pass runs, and returns one result per announcement through the stage-1 and
// output registers. The rate is set by the table RAM, which gives one read
// and one write per cycle; a request to the prefix updated by the request just
// before it sees that update through a write-forwarding register. After reset
// a clearing pass writes all PREFIX_ENTRIES (1024) rows as empty, one row per
// cycle, with in_tready low meanwhile; configuration writes are taken as usual.
`default_nettype none

module route_best_path_table (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // prefix_index, relationship, path_length, path_head_asn, next_hop,
  // rov_flag, zero pad
  input  wire logic                              in_tvalid,
  output      logic                              in_tready,
  input  wire logic [rbp_pkg::IN_TDATA_W-1:0]   in_tdata,
  // replaced, best_relationship, best_length, best_head_asn, best_next_hop,
  // best_rov, zero pad
  output      logic                              out_tvalid,
  input  wire logic                              out_tready,
  output      logic [rbp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  wire logic                              cfg_valid,
  output      logic                              cfg_ready,
  input  wire logic [rbp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rbp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  rbp_pkg::cfg_t   cfg;
  rbp_pkg::req_t   in_req;
  rbp_pkg::req_t   s1_req_r;
  logic            s1_valid_r;
  logic            s1_inrange_r;
  logic            s1_go;
  logic            in_fire;
  logic            in_range;

  logic                       clearing_r;
  logic [rbp_pkg::ADDR_W-1:0] clr_addr_r;

  logic                       fwd_valid_r;
  logic [rbp_pkg::ADDR_W-1:0] fwd_addr_r;
  rbp_pkg::entry_t            fwd_entry_r;

  logic [rbp_pkg::ENTRY_W-1:0] ram_rdata;
  logic                        ram_we;
  logic [rbp_pkg::ADDR_W-1:0]  ram_waddr;
  logic [rbp_pkg::ENTRY_W-1:0] ram_wdata;
  logic [rbp_pkg::ADDR_W-1:0]  rd_addr;
  logic [rbp_pkg::ADDR_W-1:0]  s1_addr;

  rbp_pkg::entry_t stored;
  rbp_pkg::entry_t new_entry;
  rbp_pkg::entry_t res_entry;
  logic            replace;
  logic            do_write;

  logic                            out_valid_r;
  logic [rbp_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic [rbp_pkg::OUT_TDATA_W-1:0] out_data_nxt;

  assign in_req.prefix_index  = in_tdata[9:0];
  assign in_req.relationship  = in_tdata[11:10];
  assign in_req.path_length   = in_tdata[19:12];
  assign in_req.path_head_asn = in_tdata[51:20];
  assign in_req.next_hop      = in_tdata[83:52];
  assign in_req.rov_flag      = in_tdata[84];

  assign in_range = 32'(in_req.prefix_index) < 32'(rbp_pkg::PREFIX_ENTRIES);
  assign rd_addr  = rbp_pkg::ADDR_W'(in_req.prefix_index);
  assign s1_addr  = rbp_pkg::ADDR_W'(s1_req_r.prefix_index);

  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !clearing_r && (!s1_valid_r || s1_go);
  assign in_fire   = in_tvalid && in_tready;

  rbp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rbp_ram #(
    .WIDTH (rbp_pkg::ENTRY_W),
    .DEPTH (rbp_pkg::PREFIX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire && in_range),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // latest write wins over a read that raced it
  always_comb begin
    stored = rbp_pkg::entry_t'(ram_rdata);
    if (fwd_valid_r && (fwd_addr_r == s1_addr)) begin
      stored = fwd_entry_r;
    end
  end

  rbp_pick u_pick (
    .req       (s1_req_r),
    .stored    (stored),
    .cfg       (cfg),
    .replace   (replace),
    .new_entry (new_entry)
  );

  assign do_write  = s1_go && s1_inrange_r && replace;
  assign res_entry = replace ? new_entry : stored;

  always_comb begin
    ram_we    = do_write;
    ram_waddr = s1_addr;
    ram_wdata = new_entry;
    if (clearing_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end
  end

  always_comb begin
    out_data_nxt = '0;
    if (s1_inrange_r) begin
      out_data_nxt[0]     = replace;
      out_data_nxt[2:1]   = res_entry.relationship;
      out_data_nxt[10:3]  = res_entry.length;
      out_data_nxt[42:11] = res_entry.head_asn;
      out_data_nxt[74:43] = res_entry.next_hop;
      out_data_nxt[75]    = res_entry.rov;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_addr_r  <= '0;
      fwd_valid_r <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + rbp_pkg::ADDR_W'(1);
        if (clr_addr_r == rbp_pkg::ADDR_W'(rbp_pkg::PREFIX_ENTRIES - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      if (do_write) begin
        fwd_valid_r <= 1'b1;
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r     <= in_req;
      s1_inrange_r <= in_range;
    end
    if (do_write) begin
      fwd_addr_r  <= s1_addr;
      fwd_entry_r <= new_entry;
    end
    if (s1_go) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

### rtl/rbp_ram.sv
// ----------------------------------------------------------------------------
// rbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/rbp_cfg.sv
// ----------------------------------------------------------------------------
// rbp_cfg
// Configuration registers: prepend mode and own AS number.
// ----------------------------------------------------------------------------
`default_nettype none

module rbp_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  output      logic                            cfg_ready,
  input  wire logic [rbp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rbp_pkg::CFG_DATA_W-1:0] cfg_data,
  output      rbp_pkg::cfg_t                   cfg
);

  rbp_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rbp_pkg::REG_PREPEND_MODE: cfg_r.prepend_mode <= cfg_data[0];
        rbp_pkg::REG_OWN_ASN:      cfg_r.own_asn      <= cfg_data[rbp_pkg::ASN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/rbp_pick.sv
// ----------------------------------------------------------------------------
// rbp_pick
// Prepend handling and route preference compare against the stored entry.
// ----------------------------------------------------------------------------
`default_nettype none

module rbp_pick (
  input  wire rbp_pkg::req_t   req,
  input  wire rbp_pkg::entry_t stored,
  input  wire rbp_pkg::cfg_t   cfg,
  output      logic            replace,
  output      rbp_pkg::entry_t new_entry
);

  logic [rbp_pkg::LEN_W-1:0] len;
  logic                      better;

  always_comb begin
    len = req.path_length;
    if (cfg.prepend_mode && (req.path_length < rbp_pkg::LEN_CAP)) begin
      len = req.path_length + rbp_pkg::LEN_W'(1);
    end

    new_entry.valid        = 1'b1;
    new_entry.relationship = req.relationship;
    new_entry.length       = len;
    new_entry.head_asn     = cfg.prepend_mode ? cfg.own_asn : req.path_head_asn;
    new_entry.next_hop     = req.next_hop;
    new_entry.rov          = req.rov_flag;

    // rank, then length, then next hop
    priority if (req.relationship != stored.relationship) begin
      better = req.relationship > stored.relationship;
    end else if (len != stored.length) begin
      better = len < stored.length;
    end else begin
      better = req.next_hop < stored.next_hop;
    end

    replace = !stored.valid || better;
  end

endmodule

`default_nettype wire

### rtl/rbp_checker.sv
// ----------------------------------------------------------------------------
// rbp_checker
// Port-level checks of the best-path route table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rbp_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [rbp_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // no result is left over from before reset
  a_out_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // table clearing blocks requests when reset is released
  a_busy_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> !in_tready)
    else $error("request accepted during table clear");

  // a fresh result must trace back to an accepted request
  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without a matching request");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind route_best_path_table rbp_checker u_rbp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
